// ===== design/sfbs_pkg.sv =====
package sfbs_pkg;

  // framing and escape codes
  localparam logic [7:0] FRAME_START = 8'h0A;
  localparam logic [7:0] ESC_BYTE    = 8'hDB;
  localparam logic [7:0] ESC_START   = 8'hDA;
  localparam logic [7:0] ESC_ESC     = 8'hDD;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // one frame to be sent: sample count and scaled words
  typedef struct packed {
    logic [1:0]       count;
    logic [2:0][15:0] word;
  } frame_desc_t;

endpackage

// ===== design/sfbs_queue.sv =====
module sfbs_queue #(
  parameter int unsigned WIDTH = 50,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  // status and transfer qualifiers
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/sfbs_front.sv =====
module sfbs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_data,
  input  logic                push,
  input  logic signed [15:0]  sample_one,
  input  logic signed [15:0]  sample_two,
  input  logic signed [15:0]  sample_three,
  input  logic                q_full,
  output logic                q_push,
  output sfbs_pkg::frame_desc_t q_data
);

  import sfbs_pkg::*;

  logic [1:0] channel_count;

  // scale by ten and divide by sixteen, truncating toward zero
  function automatic logic [15:0] scale(input logic [15:0] s);
    logic [19:0] ext;
    logic [19:0] prod;
    logic [19:0] biased;
    ext    = {{4{s[15]}}, s};
    prod   = (ext << 3) + (ext << 1);
    biased = prod[19] ? prod + 20'd15 : prod;
    return biased[19:4];
  endfunction

  // channel count register
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= '0;
    end else if (cfg_write) begin
      channel_count <= cfg_data;
    end
  end

  // items are dropped when frames are disabled
  assign q_push = push && !q_full && (channel_count != '0);

  // frame descriptor
  always_comb begin
    q_data.count   = channel_count;
    q_data.word[0] = scale(sample_one);
    q_data.word[1] = scale(sample_two);
    q_data.word[2] = scale(sample_three);
  end

endmodule

// ===== design/sfbs_back.sv =====
module sfbs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  sfbs_pkg::frame_desc_t q_data,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output logic [7:0]            out_byte,
  output logic                  frame_end
);

  import sfbs_pkg::*;

  logic        busy, busy_next;
  logic        esc_pend, esc_pend_next;
  logic [2:0]  pos, pos_next;
  logic        out_valid, out_valid_next;
  frame_desc_t desc, desc_next;
  logic [7:0]  esc_code, esc_code_next;
  logic [7:0]  out_byte_next;
  logic        frame_end_next;
  logic        adv;
  logic        data_last;
  logic [7:0]  cur_byte;

  assign empty = !out_valid;
  assign adv   = !out_valid || pop;

  // current data byte, high byte first per sample
  always_comb begin
    case (pos)
      3'd1:    cur_byte = desc.word[0][15:8];
      3'd2:    cur_byte = desc.word[0][7:0];
      3'd3:    cur_byte = desc.word[1][15:8];
      3'd4:    cur_byte = desc.word[1][7:0];
      3'd5:    cur_byte = desc.word[2][15:8];
      default: cur_byte = desc.word[2][7:0];
    endcase
  end

  assign data_last = (pos == {desc.count, 1'b0});

  // byte sequencer with escape insertion
  always_comb begin
    q_pop          = 1'b0;
    busy_next      = busy;
    esc_pend_next  = esc_pend;
    pos_next       = pos;
    desc_next      = desc;
    esc_code_next  = esc_code;
    out_valid_next = out_valid;
    out_byte_next  = out_byte;
    frame_end_next = frame_end;
    if (adv) begin
      out_valid_next = 1'b0;
      if (!busy) begin
        if (!q_empty) begin
          q_pop          = 1'b1;
          desc_next      = q_data;
          busy_next      = 1'b1;
          pos_next       = 3'd1;
          esc_pend_next  = 1'b0;
          out_valid_next = 1'b1;
          out_byte_next  = FRAME_START;
          frame_end_next = 1'b0;
        end
      end else if (esc_pend) begin
        out_valid_next = 1'b1;
        out_byte_next  = esc_code;
        frame_end_next = data_last;
        esc_pend_next  = 1'b0;
        if (data_last) begin
          busy_next = 1'b0;
        end else begin
          pos_next = pos + 3'd1;
        end
      end else if (cur_byte == FRAME_START || cur_byte == ESC_BYTE) begin
        out_valid_next = 1'b1;
        out_byte_next  = ESC_BYTE;
        frame_end_next = 1'b0;
        esc_pend_next  = 1'b1;
        esc_code_next  = (cur_byte == FRAME_START) ? ESC_START : ESC_ESC;
      end else begin
        out_valid_next = 1'b1;
        out_byte_next  = cur_byte;
        frame_end_next = data_last;
        if (data_last) begin
          busy_next = 1'b0;
        end else begin
          pos_next = pos + 3'd1;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      esc_pend  <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      esc_pend  <= esc_pend_next;
      pos       <= pos_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    desc      <= desc_next;
    esc_code  <= esc_code_next;
    out_byte  <= out_byte_next;
    frame_end <= frame_end_next;
  end

endmodule

// ===== design/sample_frame_byte_stuffer_unit.sv =====
// Sample frame byte stuffer: turns one item of three fixed-point samples into
// one stuffed serial frame.
// Input channel: queue style, an item transfers when push is high and full is
// low. Result channel: queue style, out_byte and frame_end are valid while
// empty is low and transfer when pop is high.
// cfg_write/cfg_data set the channel count (0 disables frames; items are
// then taken and dropped). Write it only while the block is idle.
// A frame is the start byte, then each enabled sample scaled by ten/16
// (truncated toward zero), high byte first, with escape stuffing; frame_end
// marks its last byte. A frame is 3 to 13 bytes.
// The start byte passes through the frame queue and then the output register, and
// waits while the sequencer sends an earlier frame or the receiver stalls. The
// sequencer sends one result byte per cycle while pop is high and a frame waits.
// A queue of QUEUE_DEPTH frames sits between the input and the sequencer, so
// items keep transferring while a frame is sent or the receiver stalls; when
// pop stays low the output byte holds and the queue fills, then full rises.
// Reset clears the queue, the sequencer and the channel count.
module sample_frame_byte_stuffer_unit #(
  parameter int unsigned QUEUE_DEPTH = sfbs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_data,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] sample_one,
  input  logic signed [15:0] sample_two,
  input  logic signed [15:0] sample_three,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_byte,
  output logic               frame_end
);

  import sfbs_pkg::*;

  localparam int unsigned DESC_W = $bits(frame_desc_t);

  logic        q_push, q_pop, q_full, q_empty;
  frame_desc_t q_in, q_out;

  assign full = q_full;

  // scaling and channel count gating
  sfbs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .push         (push),
    .sample_one   (sample_one),
    .sample_two   (sample_two),
    .sample_three (sample_three),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  // frame queue
  sfbs_queue #(
    .WIDTH (DESC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // byte sequencer and output register
  sfbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .frame_end (frame_end)
  );

endmodule

// ===== dv/frame_byte_checker.sv =====
module frame_byte_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_data,
  input  logic               push,
  input  logic               full,
  input  logic signed [15:0] sample_one,
  input  logic signed [15:0] sample_two,
  input  logic signed [15:0] sample_three,
  input  logic               empty,
  input  logic               pop,
  input  logic [7:0]         out_byte,
  input  logic               frame_end,
  output int                 pending_results,
  output int                 mismatch_count
);

  import sfbs_pkg::*;

  localparam int SCALE_NUM = 10;
  localparam int FRAC_DIV  = 16;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];
  logic [1:0]  channel_count = '0;
  frame_byte_t seen;

  initial begin
    pending_results = 0;
    mismatch_count  = 0;
  end

  // sample times ten over sixteen, truncated toward zero, kept as a 16-bit word
  function automatic logic [15:0] scale_sample(input logic signed [15:0] raw);
    int scaled;
    scaled = (int'(raw) * SCALE_NUM) / FRAC_DIV;
    return scaled[15:0];
  endfunction

  // data byte with escape stuffing
  function automatic void append_stuffed(input logic [7:0] data);
    if (data == FRAME_START) begin
      expected_bytes.push_back(frame_byte_t'{value: ESC_BYTE, last: 1'b0});
      expected_bytes.push_back(frame_byte_t'{value: ESC_START, last: 1'b0});
    end else if (data == ESC_BYTE) begin
      expected_bytes.push_back(frame_byte_t'{value: ESC_BYTE, last: 1'b0});
      expected_bytes.push_back(frame_byte_t'{value: ESC_ESC, last: 1'b0});
    end else begin
      expected_bytes.push_back(frame_byte_t'{value: data, last: 1'b0});
    end
  endfunction

  // whole frame for one input transfer, nothing when frames are off
  function automatic void predict_frame(input logic [1:0] count,
                                        input logic signed [15:0] first,
                                        input logic signed [15:0] second,
                                        input logic signed [15:0] third);
    logic signed [15:0] samples [3];
    logic [15:0]        word;
    if (count == 0) return;
    samples[0] = first;
    samples[1] = second;
    samples[2] = third;
    expected_bytes.push_back(frame_byte_t'{value: FRAME_START, last: 1'b0});
    for (int i = 0; i < count; i++) begin
      word = scale_sample(samples[i]);
      append_stuffed(word[15:8]);
      append_stuffed(word[7:0]);
    end
    expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin
    if (rst) begin
      expected_bytes.delete();
      channel_count = '0;
    end else begin
      // result transfer against the oldest expectation
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result byte %h (frame_end %b)", out_byte, frame_end);
          mismatch_count++;
        end else begin
          seen = expected_bytes.pop_front();
          if (out_byte !== seen.value) begin
            $error("out_byte: expected %h, got %h", seen.value, out_byte);
            mismatch_count++;
          end
          if (frame_end !== seen.last) begin
            $error("frame_end: expected %b, got %b", seen.last, frame_end);
            mismatch_count++;
          end
        end
      end
      // input transfer uses the count held before this edge
      if (push && !full) predict_frame(channel_count, sample_one, sample_two, sample_three);
      if (cfg_write) channel_count = cfg_data;
    end
    pending_results <= expected_bytes.size();
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_data = '0;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] sample_one = '0;
  logic signed [15:0] sample_two = '0;
  logic signed [15:0] sample_three = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         out_byte;
  logic               frame_end;
  int                 pending_results;
  int                 mismatch_count;

  // one in idle_odds chance, per receiver cycle and per input transfer, of starting an idle burst, 0 means none
  int idle_odds = 4;
  int stall_left = 0;
  int cycle_count = 0;

  // samples whose scaled word holds a start or escape byte, or their neighbours
  logic signed [15:0] stuffing_values [8] = '{16'sd16, 16'sd4096, 16'sd351, -16'sd15156,
                                              16'sd4447, -16'sd14805, 16'sd349, 16'sd354};

  int phase_channels [PHASES] = '{3, 1, 2, 3, 0, 2, 1, 3};
  int phase_items    [PHASES] = '{52, 52, 52, 52, 15, 52, 52, 40};
  int phase_odds     [PHASES] = '{6, 3, 10, 0, 5, 8, 4, 0};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sample_frame_byte_stuffer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .sample_one   (sample_one),
    .sample_two   (sample_two),
    .sample_three (sample_three),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .frame_end    (frame_end)
  );

  frame_byte_checker checker_inst (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .sample_one      (sample_one),
    .sample_two      (sample_two),
    .sample_three    (sample_three),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .frame_end       (frame_end),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
      pop <= 1'b0;
      stall_left <= $urandom_range(13, 1) - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9, 0))
      0: return $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
      1: return 16'(int'($urandom_range(32, 0)) - 16);
      2: return stuffing_values[$urandom_range(7, 0)];
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transfer, maybe after an idle burst
  task automatic send_samples(input logic signed [15:0] first,
                              input logic signed [15:0] second,
                              input logic signed [15:0] third);
    if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk);
    end
    push <= 1'b1;
    sample_one <= first;
    sample_two <= second;
    sample_three <= third;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // hold the sender until every expected byte has come out
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // register write once the block has gone quiet
  task automatic set_channels(input logic [1:0] count);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all three channels: extremes, rounding toward zero, stuffed bytes
    set_channels(2'd3);
    send_samples(16'sd0, 16'sd0, 16'sd0);
    send_samples(-16'sd32768, 16'sd32767, -16'sd1);
    send_samples(16'sd32767, -16'sd32768, 16'sd1);
    send_samples(16'sd16, 16'sd4096, 16'sd351);
    send_samples(-16'sd15156, 16'sd4447, -16'sd14805);
    send_samples(16'sd349, 16'sd354, -16'sd15);
    send_samples(-16'sd16, 16'sd15, -16'sd1);
    send_samples(16'sd4447, 16'sd4447, 16'sd16);

    // one channel, the rest ignored
    set_channels(2'd1);
    send_samples(16'sd16, -16'sd1, -16'sd1);
    send_samples(-16'sd15156, 16'sd16, 16'sd16);
    send_samples(-16'sd32768, 16'sd0, 16'sd0);

    // two channels
    set_channels(2'd2);
    send_samples(16'sd4447, -16'sd14805, 16'sd5);
    send_samples(16'sd32767, -16'sd32768, 16'sd0);
    send_samples(-16'sd1, 16'sd351, 16'sd4096);

    // frames off: items are taken and dropped
    set_channels(2'd0);
    send_samples(16'sd16, 16'sd16, 16'sd16);
    send_samples(-16'sd1, -16'sd1, -16'sd1);

    // random phases over all channel counts, the last with no idling
    for (int p = 0; p < PHASES; p++) begin
      set_channels(phase_channels[p][1:0]);
      idle_odds = phase_odds[p];
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 1 && i == 28) wait_drained();
        send_samples(pick_sample(), pick_sample(), pick_sample());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sfbs_pkg.sv
design/sfbs_queue.sv
design/sfbs_front.sv
design/sfbs_back.sv
design/sample_frame_byte_stuffer_unit.sv
dv/frame_byte_checker.sv
dv/testbench.sv
